// File: rtl/core/desecb_pkg.sv
// shared types, tables and des functions for the des ecb encryptor
`timescale 1ns / 1ps

package desecb_pkg;

    localparam int BLOCK_BYTES = 8;
    localparam int ROUNDS      = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [63:0] block;
        logic        last;
    } t_blk_req;

    localparam int IP_TAB [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam int FP_TAB [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam int E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };

    localparam int P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam int PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam int PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };

    // total left rotation of c and d after each round
    localparam int ROT_SUM [16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

    localparam int SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,11,3} };

    function automatic logic [63:0] f_ip(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-IP_TAB[i]];
        return r;
    endfunction

    function automatic logic [63:0] f_fp(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-FP_TAB[i]];
        return r;
    endfunction

    function automatic logic [47:0] f_e(input logic [31:0] v);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++) r[47-i] = v[32-E_TAB[i]];
        return r;
    endfunction

    function automatic logic [31:0] f_p(input logic [31:0] v);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) r[31-i] = v[32-P_TAB[i]];
        return r;
    endfunction

    function automatic logic [55:0] f_pc1(input logic [63:0] v);
        logic [55:0] r;
        r = '0;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-PC1_TAB[i]];
        return r;
    endfunction

    function automatic logic [47:0] f_pc2(input logic [55:0] v);
        logic [47:0] r;
        r = '0;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-PC2_TAB[i]];
        return r;
    endfunction

    function automatic logic [27:0] f_rotl28(input logic [27:0] x, input int n);
        logic [55:0] d;
        d = {x, x} << n;
        return d[55:28];
    endfunction

    // round subkey, pure wiring of the key for a fixed round
    function automatic logic [47:0] f_subkey(input logic [63:0] key, input int rnd);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        cd = f_pc1(key);
        c  = f_rotl28(cd[55:28], ROT_SUM[rnd]);
        d  = f_rotl28(cd[27:0], ROT_SUM[rnd]);
        return f_pc2({c, d});
    endfunction

    function automatic logic [31:0] f_round(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [5:0]  c;
        logic [31:0] s;
        x = f_e(r) ^ k;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            c = x[47-6*i -: 6];
            s[31-4*i -: 4] = 4'(SBOX[i][{c[5], c[0], c[4:1]}]);
        end
        return f_p(s);
    endfunction

    // pad bytes after cnt gathered bytes, pad value is the pad count
    function automatic logic [63:0] f_pad(input logic [55:0] part, input logic [2:0] cnt);
        logic [3:0]  pad;
        logic [63:0] b;
        pad = 4'(BLOCK_BYTES) - {1'b0, cnt};
        b   = {8'h00, part} << {pad, 3'b000};
        for (int i = 0; i < 8; i++) begin
            if (i < pad) b[8*i +: 8] = {4'h0, pad};
        end
        return b;
    endfunction

endpackage

// File: rtl/core/des_ecb_encrypt_padded_top.sv
// top level of the des ecb encryptor with pkcs5 padding
// Takes one plaintext request per cycle while o_stall is low (a byte, an end marker, or
// both) and returns 64-bit DES-ECB ciphertext blocks, first byte in the top bits, with
// PKCS#5 padding added at message end; last_block marks the final block of each message.
// The cipher is a sixteen-stage round pipeline, one round per stage, so one block enters
// per cycle unless the output stalls. A message end that both fills a block and needs a
// whole pad block produces two blocks and holds the input until the pad block is pushed.
// The key register is read live by the rounds, so the user must write it only while no
// block is in flight; this module does not enforce it. No clearing pass follows reset.
`timescale 1ns / 1ps

module des_ecb_encrypt_padded_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_des_key_we,
    input  logic [63:0] i_des_key_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_cipher_block,
    output logic        o_last_block
);
    import desecb_pkg::*;

    logic [63:0] r_des_key;
    logic        push;
    t_blk_req    push_req;
    logic        q_full;
    logic        q_valid;
    t_blk_req    q_req;
    logic        q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_des_key <= '0;
        end else if (i_des_key_we) begin
            r_des_key <= i_des_key_wdata;
        end
    end

    desecb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_has_byte  (i_has_byte),
        .i_is_last   (i_is_last),
        .o_push      (push),
        .o_req       (push_req),
        .i_q_full    (q_full)
    );

    desecb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    desecb_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key          (r_des_key),
        .i_req_valid    (q_valid),
        .i_req          (q_req),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cipher_block (o_cipher_block),
        .o_last_block   (o_last_block)
    );

endmodule

// File: rtl/core/desecb_front.sv
// front end: gathers bytes into blocks and issues padded block requests
`timescale 1ns / 1ps

module desecb_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_has_byte,
    input  logic                  i_is_last,
    output logic                  o_push,
    output desecb_pkg::t_blk_req  o_req,
    input  logic                  i_q_full
);
    import desecb_pkg::*;

    logic [55:0] r_part;
    logic [2:0]  r_cnt;
    logic        r_pend;
    logic [55:0] n_part;
    logic [2:0]  n_cnt;
    logic        n_pend;
    logic [55:0] upd_part;
    logic [2:0]  upd_cnt;
    logic        acc;
    logic        full_hit;

    assign o_stall  = r_pend || i_q_full;
    assign acc      = i_valid && !o_stall;
    assign full_hit = i_has_byte && (r_cnt == 3'(BLOCK_BYTES - 1));

    always_comb begin
        n_part      = r_part;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        upd_part    = r_part;
        upd_cnt     = r_cnt;
        o_push      = 1'b0;
        o_req.block = f_pad(56'h0, 3'h0);
        o_req.last  = 1'b1;
        if (r_pend) begin
            // extra pad block after a message that ended on a block edge
            if (!i_q_full) begin
                o_push = 1'b1;
                n_pend = 1'b0;
            end
        end else if (acc) begin
            if (i_has_byte) begin
                if (full_hit) begin
                    o_push      = 1'b1;
                    o_req.block = {r_part, i_data_byte};
                    o_req.last  = 1'b0;
                    upd_part    = '0;
                    upd_cnt     = '0;
                end else begin
                    upd_part = {r_part[47:0], i_data_byte};
                    upd_cnt  = r_cnt + 3'd1;
                end
            end
            n_part = upd_part;
            n_cnt  = upd_cnt;
            if (i_is_last) begin
                if (full_hit) begin
                    n_pend = 1'b1;
                end else begin
                    o_push      = 1'b1;
                    o_req.block = f_pad(upd_part, upd_cnt);
                    o_req.last  = 1'b1;
                end
                n_part = '0;
                n_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_part <= n_part;
            r_cnt  <= n_cnt;
            r_pend <= n_pend;
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("block request pushed into a full queue");

    a_pend_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && full_hit && i_is_last) |=> (r_pend && r_cnt == 3'd0))
        else $error("pad block not scheduled after full final block");

endmodule

// File: rtl/core/desecb_fifo.sv
// short request queue between the front end and the cipher pipeline
`timescale 1ns / 1ps

module desecb_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  desecb_pkg::t_blk_req  i_req,
    output logic                  o_full,
    output logic                  o_valid,
    output desecb_pkg::t_blk_req  o_req,
    input  logic                  i_pop
);
    import desecb_pkg::*;

    t_blk_req          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr;
    logic              rd;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({wr, rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

// File: rtl/core/desecb_core.sv
// back end: sixteen-stage des round pipeline with output register
`timescale 1ns / 1ps

module desecb_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [63:0]           i_key,
    input  logic                  i_req_valid,
    input  desecb_pkg::t_blk_req  i_req,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [63:0]           o_cipher_block,
    output logic                  o_last_block
);
    import desecb_pkg::*;

    logic [31:0] r_l   [0:ROUNDS];
    logic [31:0] r_r   [0:ROUNDS];
    logic        r_lst [0:ROUNDS];
    logic        r_vld [0:ROUNDS];
    logic        r_out_valid;
    logic [63:0] r_out_block;
    logic        r_out_last;
    logic [63:0] w_ip;
    logic [47:0] w_subkey [ROUNDS];
    logic        adv;

    assign adv            = !r_out_valid || !i_stall;
    assign o_pop          = adv && i_req_valid;
    assign w_ip           = f_ip(i_req.block);
    assign o_valid        = r_out_valid;
    assign o_cipher_block = r_out_block;
    assign o_last_block   = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ROUNDS; k++) r_vld[k] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_req_valid;
            for (int k = 1; k <= ROUNDS; k++) r_vld[k] <= r_vld[k-1];
            r_out_valid <= r_vld[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l[0]      <= w_ip[63:32];
            r_r[0]      <= w_ip[31:0];
            r_lst[0]    <= i_req.last;
            r_out_block <= f_fp({r_r[ROUNDS], r_l[ROUNDS]});
            r_out_last  <= r_lst[ROUNDS];
        end
    end

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        assign w_subkey[g] = f_subkey(i_key, g);

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_l[g+1]   <= r_r[g];
                r_r[g+1]   <= r_l[g] ^ f_round(r_r[g], w_subkey[g]);
                r_lst[g+1] <= r_lst[g];
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out_block)))
        else $error("stalled cipher block lost or changed");

endmodule
